### rtl/fnvh_pkg.sv
// fnvh_pkg: constants, register indexes and controller/datapath structs
// for the chained fnv-1a name hash; no dependencies
package fnvh_pkg;

  localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
  // fnv prime is 2^40 + 0x1b3
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam int          FNV_TOP_BITS = 64 - FNV_PRIME_SHIFT;
  localparam logic [63:0] MIX_CONST = 64'hd6e8feb86659fd93;
  localparam logic [63:0] SEED_RESET = 64'h50584d4c;
  localparam logic        CHAIN_RESET = 1'b1;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_START_SEED = 1'b0;
  localparam cfg_index_t REG_CHAIN_MODE = 1'b1;

  typedef struct packed {
    logic load_item;  // latch the byte of an accepted transaction
    logic byte_mul;   // xor byte in, multiply by low part of prime
    logic byte_add;   // add the 2^40 term of the prime
    logic fin_m0;     // low x low partial product
    logic fin_m1;     // high x low partial product
    logic fin_m2;     // low x high partial product
    logic fin_m3;     // fold last partial product
    logic fin_out;    // final xor-shift, load result, reseed
  } fnvh_cmd_t;

  typedef struct packed {
    logic result_free;  // result register can take a value this cycle
  } fnvh_status_t;

endpackage

### rtl/fnvh_ctrl.sv
// fnvh_ctrl: controller state machine for the chained fnv-1a name hash
// depends on fnvh_pkg (command and status structs)
module fnvh_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  byte_present,
  input  logic                  segment_end,
  input  fnvh_pkg::fnvh_status_t status,
  output fnvh_pkg::fnvh_cmd_t    cmd
);
  import fnvh_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_BYTE_MUL = 8'b0000_0010,
    S_BYTE_ADD = 8'b0000_0100,
    S_FIN_M0   = 8'b0000_1000,
    S_FIN_M1   = 8'b0001_0000,
    S_FIN_M2   = 8'b0010_0000,
    S_FIN_M3   = 8'b0100_0000,
    S_FIN_OUT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   end_pending, end_pending_next;
  logic   accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next       = state;
    end_pending_next = end_pending;
    cmd              = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_item    = 1'b1;
          end_pending_next = segment_end;
          if (byte_present) begin
            state_next = S_BYTE_MUL;
          end else if (segment_end) begin
            state_next = S_FIN_M0;
          end
        end
      end
      S_BYTE_MUL: begin
        cmd.byte_mul = 1'b1;
        state_next   = S_BYTE_ADD;
      end
      S_BYTE_ADD: begin
        cmd.byte_add = 1'b1;
        state_next   = end_pending ? S_FIN_M0 : S_IDLE;
      end
      S_FIN_M0: begin
        cmd.fin_m0 = 1'b1;
        state_next = S_FIN_M1;
      end
      S_FIN_M1: begin
        cmd.fin_m1 = 1'b1;
        state_next = S_FIN_M2;
      end
      S_FIN_M2: begin
        cmd.fin_m2 = 1'b1;
        state_next = S_FIN_M3;
      end
      S_FIN_M3: begin
        cmd.fin_m3 = 1'b1;
        state_next = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        // hold here while the previous result is still waiting
        if (status.result_free) begin
          cmd.fin_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      end_pending <= 1'b0;
    end else begin
      state       <= state_next;
      end_pending <= end_pending_next;
    end
  end

endmodule

### rtl/fnvh_dp.sv
// fnvh_dp: datapath of the chained fnv-1a name hash (hash state, shared
// 32x32 multiplier, config registers, result register); depends on fnvh_pkg
module fnvh_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  fnvh_pkg::cfg_index_t   cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic [7:0]             data_byte,
  input  fnvh_pkg::fnvh_cmd_t    cmd,
  output fnvh_pkg::fnvh_status_t status,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [63:0]            hash_full,
  output logic [31:0]            hash_folded,
  output logic                   segment_kind
);
  import fnvh_pkg::*;

  logic [63:0] start_seed;
  logic        chain_mode;
  logic [63:0] running_hash;
  logic        name_phase;

  logic [7:0]              byte_q;
  logic [FNV_TOP_BITS-1:0] x_low;
  logic [63:0]             prod;
  logic [63:0]             acc;

  logic [63:0] x_val;
  logic [63:0] mix_val;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] fin_val;

  assign x_val   = running_hash ^ {56'b0, byte_q};
  assign mix_val = running_hash ^ {32'b0, running_hash[63:32]};
  assign fin_val = acc ^ {32'b0, acc[63:32]};

  // operand select for the shared multiplier
  always_comb begin
    priority if (cmd.fin_m1) begin
      mul_a = mix_val[63:32];
      mul_b = MIX_CONST[31:0];
    end else if (cmd.fin_m2) begin
      mul_a = mix_val[31:0];
      mul_b = MIX_CONST[63:32];
    end else begin
      mul_a = mix_val[31:0];
      mul_b = MIX_CONST[31:0];
    end
  end

  assign status.result_free = !result_valid || result_ready;

  // datapath working registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      byte_q <= data_byte;
    end
    if (cmd.byte_mul) begin
      prod  <= 64'(x_val * {55'b0, FNV_PRIME_LO});
      x_low <= x_val[FNV_TOP_BITS-1:0];
    end else if (cmd.fin_m0 || cmd.fin_m1 || cmd.fin_m2) begin
      prod <= {32'b0, mul_a} * {32'b0, mul_b};
    end
    if (cmd.fin_m1) begin
      acc <= prod;
    end else if (cmd.fin_m2 || cmd.fin_m3) begin
      acc[63:32] <= acc[63:32] + prod[31:0];
    end
    if (cmd.fin_out) begin
      hash_full    <= fin_val;
      hash_folded  <= fin_val[31:0] ^ fin_val[63:32];
      segment_kind <= chain_mode && name_phase;
    end
  end

  // hash state, config and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      start_seed   <= SEED_RESET;
      chain_mode   <= CHAIN_RESET;
      running_hash <= OFFSET_BASIS ^ SEED_RESET;
      name_phase   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_START_SEED: begin
            start_seed   <= cfg_data;
            running_hash <= OFFSET_BASIS ^ cfg_data;
          end
          REG_CHAIN_MODE: begin
            chain_mode   <= cfg_data[0];
            running_hash <= OFFSET_BASIS ^ start_seed;
          end
          default: begin
            running_hash <= OFFSET_BASIS ^ start_seed;
          end
        endcase
        name_phase <= 1'b0;
      end else if (cmd.byte_add) begin
        running_hash <= prod + {x_low, {FNV_PRIME_SHIFT{1'b0}}};
      end else if (cmd.fin_out) begin
        if (chain_mode && !name_phase) begin
          running_hash <= OFFSET_BASIS ^ fin_val;
          name_phase   <= 1'b1;
        end else begin
          running_hash <= OFFSET_BASIS ^ start_seed;
          name_phase   <= 1'b0;
        end
      end
      if (cmd.fin_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/fnv1a_chained_name_hash.sv
// fnv1a_chained_name_hash: top level, joins controller and datapath
// depends on fnvh_pkg, fnvh_ctrl, fnvh_dp
//
// sequencing: a marker-only transaction is taken in the idle state alone; a byte
//   then walks xor and 64x9 multiply, then add of the 2^40 term of the prime
// segment end adds three partial products on a shared 32x32 multiplier,
//   one fold and one result load; the result load waits while the previous
//   result is still held downstream
// reset: synchronous, clears the state machine and result valid, restores
//   start_seed, chain_mode and the running hash to their reset values
module fnv1a_chained_name_hash (
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_write,
  input  fnvh_pkg::cfg_index_t cfg_index,
  input  logic [63:0]          cfg_data,
  // byte transactions
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [7:0]           data_byte,
  input  logic                 byte_present,
  input  logic                 segment_end,
  // result transactions
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [63:0]          hash_full,
  output logic [31:0]          hash_folded,
  output logic                 segment_kind
);
  import fnvh_pkg::*;

  fnvh_cmd_t    cmd;
  fnvh_status_t status;

  // sequencer: one transaction at a time, walks the byte and finalize steps
  fnvh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .byte_present (byte_present),
    .segment_end  (segment_end),
    .status       (status),
    .cmd          (cmd)
  );

  // hash state, multiplier and result register; the result register lets
  // new bytes be taken while a finished hash still waits downstream
  fnvh_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hash_full    (hash_full),
    .hash_folded  (hash_folded),
    .segment_kind (segment_kind)
  );

endmodule

### rtl/fnvh_checker.sv
// fnvh_checker: port-level assertions for fnv1a_chained_name_hash
// depends only on the top level's ports; bound to the top level at the end of this file
module fnvh_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input logic                 byte_present,
  input logic                 segment_end,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [63:0]          hash_full,
  input logic [31:0]          hash_folded,
  input logic                 segment_kind
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // folded value matches the full hash it goes with whenever a result is valid
  a_fold: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hash_folded == (hash_full[31:0] ^ hash_full[63:32])))
    else $error("folded hash mismatch");

  // a marker-only transaction without end leaves the block ready
  a_marker_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && !byte_present && !segment_end) |=> item_ready)
    else $error("marker-only transaction stalled input");

  // stalled result stays valid
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> ($stable(hash_full) && $stable(segment_kind)))
    else $error("result payload changed while stalled");

endmodule

bind fnv1a_chained_name_hash fnvh_checker u_fnvh_checker (.*);
